// File: rtl/ple_pkg.sv
// shared constants, types and command struct for the positional list engine
`default_nettype none
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int DATAW    = 32;
    localparam int POSW     = 7;
    localparam int STW      = 3;
    localparam int SUMW     = 38;
    localparam int IDXW     = $clog2(CAPACITY);
    localparam int CNTW     = $clog2(CAPACITY + 1);
    localparam int CW       = ((POSW > CNTW) ? POSW : CNTW) + 1;
    localparam int GRP      = 8;
    localparam int GBW      = $clog2(GRP);
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int GW       = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int SW       = GW + GBW + 1;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_DELETE   = 2'd1,
        REQ_SEARCH   = 2'd2,
        REQ_DEL_LAST = 2'd3
    } t_req;

    typedef enum logic [STW-1:0] {
        ST_OK        = 3'd0,
        ST_BADPOS    = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             cmp;
        logic [IDXW-1:0]  idx;
        logic [CNTW-1:0]  count;
        logic [DATAW-1:0] value;
    } t_cell_cmd;

    typedef struct packed {
        logic            done;
        logic            found;
        logic [IDXW-1:0] idx;
    } t_srch_res;

endpackage
`default_nettype wire

// File: rtl/positional_list_engine.sv
// top level of the positional list engine: cell row, search scanner, bookkeeping
//
// ordered list of up to CAPACITY signed 32-bit entries held in a row of cells
// command channel: a transaction is taken at a clock edge with i_start high and
// o_busy low; i_req_type selects insert at position, delete at position,
// search for value or delete last entry
// result channel: o_valid is high for exactly one cycle per transaction and
// carries status, found position, removed value, length, negative count, sum
// insert and delete finish in the cells: the result follows in the cycle after
// acceptance, and a new transaction may follow on every cycle
// search latches the cell compares, then scans the match flags eight cells
// per cycle until the first match or the last group, o_busy high
// until the result cycle
// reset clears length, negative count and sum; cell contents stay undefined
// but are never read beyond the current length
// the receiver cannot stall: each result is taken in its strobe cycle
`default_nettype none
module positional_list_engine
    import ple_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic [1:0]       i_req_type,
    input  wire logic [POSW-1:0]  i_position,
    input  wire logic [DATAW-1:0] i_value,
    output logic                  o_valid,
    output logic [STW-1:0]        o_status,
    output logic [POSW-1:0]       o_found_position,
    output logic [DATAW-1:0]      o_removed_value,
    output logic [POSW-1:0]       o_list_length,
    output logic [POSW-1:0]       o_negative_count,
    output logic [SUMW-1:0]       o_total_sum
);

    logic [CNTW-1:0]  r_count, n_count;
    logic [CNTW-1:0]  r_neg, n_neg;
    logic [SUMW-1:0]  r_sum, n_sum;
    logic             r_valid;
    logic [STW-1:0]   r_status;
    logic [POSW-1:0]  r_found;
    logic [DATAW-1:0] r_removed;
    logic [POSW-1:0]  r_len;
    logic [POSW-1:0]  r_negout;
    logic [SUMW-1:0]  r_sumout;

    logic             w_accept;
    logic             w_is_search;
    logic [CW-1:0]    w_pos;
    logic [CW-1:0]    w_cnt;
    logic             w_do_ins;
    logic             w_do_del;
    logic [IDXW-1:0]  w_idx;
    t_status          w_status;
    logic [DATAW-1:0] w_removed;
    logic [DATAW-1:0] w_res_removed;
    t_cell_cmd        w_cmd;
    t_srch_res        w_srch;
    logic             w_busy;

    logic [DATAW-1:0]    w_data [CAPACITY];
    logic [DATAW-1:0]    w_hit  [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    assign o_busy      = w_busy;
    assign w_accept    = i_start && !w_busy;
    assign w_is_search = (t_req'(i_req_type) == REQ_SEARCH);
    assign w_pos       = CW'(i_position);
    assign w_cnt       = CW'(r_count);

    always_comb begin
        w_status = ST_OK;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        w_idx    = IDXW'(w_pos - CW'(1));
        case (t_req'(i_req_type))
            REQ_INSERT: begin
                if ((w_pos == '0) || (w_pos > w_cnt + CW'(1))) begin
                    w_status = ST_BADPOS;
                end else if (r_count == CNTW'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if ((w_pos == '0) || (w_pos > w_cnt)) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_do_del = 1'b1;
                end
            end
            REQ_DEL_LAST: begin
                w_idx = IDXW'(r_count - CNTW'(1));
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_do_del = 1'b1;
                end
            end
            default: begin
                w_status = ST_NOT_FOUND;
            end
        endcase
    end

    assign w_cmd.ins   = w_accept && w_do_ins;
    assign w_cmd.del   = w_accept && w_do_del;
    assign w_cmd.cmp   = w_accept && w_is_search;
    assign w_cmd.idx   = w_idx;
    assign w_cmd.count = r_count;
    assign w_cmd.value = i_value;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATAW-1:0] w_left;
        logic [DATAW-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_data[k+1];
        end
        ple_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDXW'(k)),
            .i_cmd      (w_cmd),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_data     (w_data[k]),
            .o_hit_data (w_hit[k]),
            .o_match    (w_match[k])
        );
    end

    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_removed = w_removed | w_hit[k];
        end
    end

    ple_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cmd.cmp),
        .i_match (w_match),
        .o_busy  (w_busy),
        .o_res   (w_srch)
    );

    always_comb begin
        n_count       = r_count;
        n_neg         = r_neg;
        n_sum         = r_sum;
        w_res_removed = '0;
        if (w_do_ins) begin
            n_count = r_count + CNTW'(1);
            n_sum   = r_sum + {{(SUMW-DATAW){i_value[DATAW-1]}}, i_value};
            if (i_value[DATAW-1]) begin
                n_neg = r_neg + CNTW'(1);
            end
        end else if (w_do_del) begin
            w_res_removed = w_removed;
            n_count = r_count - CNTW'(1);
            n_sum   = r_sum - {{(SUMW-DATAW){w_removed[DATAW-1]}}, w_removed};
            if (w_removed[DATAW-1] && (r_neg != '0)) begin
                n_neg = r_neg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_neg   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (w_accept && !w_is_search) || w_srch.done;
            if (w_accept && !w_is_search) begin
                r_count <= n_count;
                r_neg   <= n_neg;
                r_sum   <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_srch.done) begin
            r_status  <= w_srch.found ? ST_OK : ST_NOT_FOUND;
            r_found   <= w_srch.found ? POSW'(CNTW'(w_srch.idx) + CNTW'(1)) : '0;
            r_removed <= '0;
            r_len     <= POSW'(r_count);
            r_negout  <= POSW'(r_neg);
            r_sumout  <= r_sum;
        end else if (w_accept) begin
            r_status  <= w_status;
            r_found   <= '0;
            r_removed <= w_res_removed;
            r_len     <= POSW'(n_count);
            r_negout  <= POSW'(n_neg);
            r_sumout  <= n_sum;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_removed_value  = r_removed;
    assign o_list_length    = r_len;
    assign o_negative_count = r_negout;
    assign o_total_sum      = r_sumout;

    a_list_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_search) |=> o_valid)
        else $error("no result after list transaction");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_search) |=> (o_busy && !o_valid))
        else $error("search not held busy");

    a_neg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_neg <= r_count) && (r_count <= CNTW'(CAPACITY)))
        else $error("negative count or length out of bounds");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_do_ins) |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("insert did not grow the list");

    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_found_position == '0))
        else $error("position given without a match");

endmodule
`default_nettype wire

// File: rtl/ple_cell.sv
// one list cell: holds an entry, shifts with its neighbors, compares for search
`default_nettype none
module ple_cell
    import ple_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [IDXW-1:0]  i_index,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic [DATAW-1:0] i_left,
    input  wire logic [DATAW-1:0] i_right,
    output logic      [DATAW-1:0] o_data,
    output logic      [DATAW-1:0] o_hit_data,
    output logic                  o_match
);

    logic [DATAW-1:0] r_data;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (i_index == i_cmd.idx) begin
                r_data <= i_cmd.value;
            end else if (i_index > i_cmd.idx) begin
                r_data <= i_left;
            end
        end else if (i_cmd.del && (i_index >= i_cmd.idx)) begin
            r_data <= i_right;
        end
        if (i_cmd.cmp) begin
            r_match <= (r_data == i_cmd.value) && (CNTW'(i_index) < i_cmd.count);
        end
    end

    assign o_data     = r_data;
    assign o_hit_data = (i_index == i_cmd.idx) ? r_data : '0;
    assign o_match    = r_match;

endmodule
`default_nettype wire

// File: rtl/ple_search.sv
// first-match scanner over the cell match flags, one group of cells per cycle
`default_nettype none
module ple_search
    import ple_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [CAPACITY-1:0] i_match,
    output logic                     o_busy,
    output t_srch_res                o_res
);

    logic                  r_active;
    logic [GW-1:0]         r_grp;
    logic [NGRP*GRP-1:0]   w_pad;
    logic [GRP-1:0]        w_sel;
    logic [GBW-1:0]        w_ffs;
    logic                  w_any;
    logic                  w_last;
    logic [SW-1:0]         w_pos;

    always_comb begin
        w_pad = '0;
        w_pad[CAPACITY-1:0] = i_match;
        w_sel = w_pad[r_grp*GRP +: GRP];
        w_any = |w_sel;
        w_ffs = '0;
        for (int b = GRP - 1; b >= 0; b--) begin
            if (w_sel[b]) begin
                w_ffs = GBW'(b);
            end
        end
        w_last = (r_grp == GW'(NGRP - 1));
        w_pos  = SW'(r_grp) * SW'(GRP) + SW'(w_ffs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_grp    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_grp    <= '0;
        end else if (r_active) begin
            if (w_any || w_last) begin
                r_active <= 1'b0;
            end else begin
                r_grp <= r_grp + GW'(1);
            end
        end
    end

    assign o_busy      = r_active;
    assign o_res.done  = r_active && (w_any || w_last);
    assign o_res.found = w_any;
    assign o_res.idx   = IDXW'(w_pos);

endmodule
`default_nettype wire
